// ===== rtl/nrsf_pkg.sv =====
// nrsf_pkg: shared types and constants for the rmc sentence framer
// used by nrsf_ctrl, nrsf_dp and the top level; depends on nothing

package nrsf_pkg;

    // header window and chunk geometry
    localparam int HDR_LEN     = 6;
    localparam int HDR_BITS    = HDR_LEN * 8;
    localparam int CHUNK_BYTES = 8;
    localparam int MAX_EMIT    = 128;
    localparam int OUT_TDATA_W = 80;

    localparam logic [7:0] STAR_CHAR = 8'h2A;

    // "$GPRMC" and "$GNRMC", first character in the lowest byte
    localparam logic [HDR_BITS-1:0] HDR_GP = {8'h43, 8'h4D, 8'h52, 8'h50, 8'h47, 8'h24};
    localparam logic [HDR_BITS-1:0] HDR_GN = {8'h43, 8'h4D, 8'h52, 8'h4E, 8'h47, 8'h24};

    // commands from controller to datapath
    typedef struct packed {
        logic take;   // input transaction accepted this cycle
        logic issue;  // issue one sentence byte read
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic hit;        // current byte completes a valid checksum
        logic chunk_end;  // read being issued is the last of its chunk
        logic last_chunk; // chunk on the output is the final one
    } t_stat;

    // hex digit decode: bit 4 set when the character is a hex digit
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            res = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            res = {1'b1, 4'(c - 8'h37)};
        end
        return res;
    endfunction

    // checksum value from the two digits after '*'
    function automatic logic [7:0] checksum_value(input logic [7:0] d0, input logic [7:0] d1);
        logic [4:0] h0;
        logic [4:0] h1;
        logic [7:0] res;
        h0 = hex_decode(d0);
        h1 = hex_decode(d1);
        if (!h0[4]) begin
            res = 8'd0;
        end else if (!h1[4]) begin
            res = {4'd0, h0[3:0]};
        end else begin
            res = {h0[3:0], h1[3:0]};
        end
        return res;
    endfunction

endpackage

// ===== rtl/nrsf_ctrl.sv =====
// nrsf_ctrl: controller state machine of the rmc sentence framer
// depends on nrsf_pkg (command and status structs)

module nrsf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    input  nrsf_pkg::t_stat i_stat,
    output nrsf_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_LAND = 4'b0100,
        S_SEND = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd.take  = 1'b0;
        o_cmd.issue = 1'b0;
        o_s_tready  = 1'b0;
        o_m_tvalid  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.take = 1'b1;
                    if (i_stat.hit) begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                o_cmd.issue = 1'b1;
                if (i_stat.chunk_end) begin
                    n_state = S_LAND;
                end
            end
            S_LAND: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                o_m_tvalid = 1'b1;
                if (i_m_tready) begin
                    n_state = i_stat.last_chunk ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/nrsf_dp.sv =====
// nrsf_dp: datapath of the rmc sentence framer (header window, sentence
// memory, checksum check, chunk assembly); depends on nrsf_pkg

module nrsf_dp #(
    parameter int BUFFER_BYTES = 128
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic [7:0]                               i_rx_byte,
    input  nrsf_pkg::t_cmd                           i_cmd,
    output nrsf_pkg::t_stat                          o_stat,
    output logic [nrsf_pkg::CHUNK_BYTES*8-1:0]       o_bytes,
    output logic [3:0]                               o_bytes_in_chunk,
    output logic [7:0]                               o_sentence_length
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int FW = $clog2(BUFFER_BYTES + 1);
    localparam int HB = nrsf_pkg::HDR_BITS;

    // sentence memory, header bytes live in the window register instead
    logic [7:0] mem [BUFFER_BYTES];
    logic [7:0] r_mem_q;

    logic [HB-1:0] r_win;
    logic [7:0]    r_prev1;
    logic [7:0]    r_prev2;
    logic [7:0]    r_xor;
    logic [FW-1:0] r_fill;
    logic [FW-1:0] r_len;
    logic [FW-1:0] r_emit;
    logic [FW-1:0] r_rd_idx;

    logic          r_land_v;
    logic [2:0]    r_land_slot;
    logic          r_land_hdr;
    logic [7:0]    r_land_hbyte;
    logic          r_land_last;

    logic [nrsf_pkg::CHUNK_BYTES*8-1:0] r_bytes;
    logic [3:0]    r_bic;
    logic          r_last;

    logic [HB-1:0] n_win;
    logic          w_hunting;
    logic          w_overflow;
    logic          w_store;
    logic          w_hdr_ok;
    logic [7:0]    w_win_xor;
    logic [7:0]    w_sum;
    logic          w_hit;
    logic [FW-1:0] w_len;
    logic [8:0]    w_len9;
    logic [FW-1:0] w_emit;
    logic          w_rd_last;
    logic [7:0]    w_hdr_byte;
    logic [7:0]    w_land_byte;

    // per-byte decisions
    always_comb begin
        w_hunting  = r_fill < FW'(nrsf_pkg::HDR_LEN);
        w_overflow = !w_hunting && (r_fill >= FW'(BUFFER_BYTES));
        w_store    = !w_hunting && !w_overflow;
        n_win      = {i_rx_byte, r_win[HB-1:8]};
        w_hdr_ok   = (n_win == nrsf_pkg::HDR_GP) || (n_win == nrsf_pkg::HDR_GN);
        w_win_xor  = n_win[15:8] ^ n_win[23:16] ^ n_win[31:24] ^ n_win[39:32]
                     ^ n_win[47:40];
        w_sum      = r_xor ^ nrsf_pkg::STAR_CHAR ^ r_prev1;
        w_hit      = w_store && (r_prev2 == nrsf_pkg::STAR_CHAR)
                     && (w_sum == nrsf_pkg::checksum_value(r_prev1, i_rx_byte));
        w_len      = r_fill + FW'(1);
        w_len9     = 9'(w_len);
        w_emit     = (w_len9 > 9'(nrsf_pkg::MAX_EMIT)) ? FW'(nrsf_pkg::MAX_EMIT) : w_len;
    end

    // header byte for the read being issued
    always_comb begin
        case (r_rd_idx[2:0])
            3'd0:    w_hdr_byte = r_win[7:0];
            3'd1:    w_hdr_byte = r_win[15:8];
            3'd2:    w_hdr_byte = r_win[23:16];
            3'd3:    w_hdr_byte = r_win[31:24];
            3'd4:    w_hdr_byte = r_win[39:32];
            3'd5:    w_hdr_byte = r_win[47:40];
            default: w_hdr_byte = 8'd0;
        endcase
    end

    assign w_rd_last   = (r_rd_idx == r_emit - FW'(1));
    assign w_land_byte = r_land_hdr ? r_land_hbyte : r_mem_q;

    // sentence state: running xor, fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_xor  <= 8'd0;
        end else if (i_cmd.take) begin
            if (w_hunting) begin
                if (r_fill == FW'(nrsf_pkg::HDR_LEN - 1) && !w_hdr_ok) begin
                    r_fill <= r_fill;
                end else begin
                    r_fill <= r_fill + FW'(1);
                end
                if (r_fill == FW'(nrsf_pkg::HDR_LEN - 1) && w_hdr_ok) begin
                    r_xor <= w_win_xor;
                end
            end else if (w_overflow || w_hit) begin
                r_fill <= '0;
                r_xor  <= 8'd0;
            end else begin
                r_fill <= r_fill + FW'(1);
                r_xor  <= r_xor ^ i_rx_byte;
            end
        end
    end

    // payload side of the byte path
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && w_hunting) begin
            r_win <= n_win;
        end
        if (i_cmd.take && (w_hunting || w_store)) begin
            r_prev1 <= i_rx_byte;
            r_prev2 <= r_prev1;
        end
        if (i_cmd.take && w_hit) begin
            r_len  <= w_len;
            r_emit <= w_emit;
        end
    end

    // sentence memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && w_store) begin
            mem[r_fill[AW-1:0]] <= i_rx_byte;
        end
        r_mem_q <= mem[r_rd_idx[AW-1:0]];
    end

    // read pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
        end else if (i_cmd.take && w_hit) begin
            r_rd_idx <= '0;
        end else if (i_cmd.issue) begin
            r_rd_idx <= r_rd_idx + FW'(1);
        end
    end

    // landing stage tracks the read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_land_v <= 1'b0;
        end else begin
            r_land_v <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_land_slot  <= r_rd_idx[2:0];
            r_land_hdr   <= r_rd_idx < FW'(nrsf_pkg::HDR_LEN);
            r_land_hbyte <= w_hdr_byte;
            r_land_last  <= w_rd_last;
        end
    end

    // chunk assembly, unused byte fields read as zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue && r_rd_idx[2:0] == 3'd0) begin
            r_bytes <= '0;
        end
        if (r_land_v) begin
            r_bytes[{r_land_slot, 3'b000} +: 8] <= w_land_byte;
            r_bic  <= {1'b0, r_land_slot} + 4'd1;
            r_last <= r_land_last;
        end
    end

    assign o_stat.hit        = w_hit;
    assign o_stat.chunk_end  = (r_rd_idx[2:0] == 3'd7) || w_rd_last;
    assign o_stat.last_chunk = r_last;

    assign o_bytes           = r_bytes;
    assign o_bytes_in_chunk  = r_bic;
    assign o_sentence_length = 8'(r_len);

endmodule

// ===== rtl/nmea_rmc_sentence_framer.sv =====
// Usage: byte-wide serial input on the slave stream (i_s_tdata holds one raw
// received character). The block hunts for "$GPRMC" / "$GNRMC", buffers the
// sentence and checks the '*' checksum against the two hex digits after it.
// On a checksum match the sentence, '$' through the last checksum digit, goes
// out on the master stream as 8-byte chunks, tlast on the final chunk.
// Input: one byte per cycle while no sentence is being sent; o_s_tready drops
// for the duration of sentence output.
// Output: once the final checksum digit is accepted, the bytes of each chunk are
// read through the single read port of the sentence memory and land in the
// landing register; the chunk is then offered on the master stream, and reads
// for the next chunk start once it is taken.
// Receiver stall: the chunk holds on o_m_tdata/o_m_tlast until i_m_tready;
// no input is taken meanwhile, so no byte is lost.
// Reset (i_rst_n low, synchronous): hunting restarts, buffer logically empty;
// no memory clearing pass is needed.
// Bytes arriving with the buffer full are dropped and hunting restarts.
// Depends on nrsf_pkg, nrsf_ctrl, nrsf_dp.

module nmea_rmc_sentence_framer #(
    parameter int BUFFER_BYTES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    // master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [nrsf_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // [7:0] byte_0 .. [63:56] byte_7, [67:64] bytes_in_chunk,
    // [75:68] sentence_length, [79:76] zero
    output logic        o_m_tlast    // last_chunk
);

    nrsf_pkg::t_cmd  w_cmd;
    nrsf_pkg::t_stat w_stat;

    logic [nrsf_pkg::CHUNK_BYTES*8-1:0] w_bytes;
    logic [3:0]                         w_bic;
    logic [7:0]                         w_len;

    // control
    nrsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // datapath
    nrsf_dp #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_rx_byte         (i_s_tdata),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .o_bytes           (w_bytes),
        .o_bytes_in_chunk  (w_bic),
        .o_sentence_length (w_len)
    );

    // output packing
    assign o_m_tdata = {4'd0, w_len, w_bic, w_bytes};
    assign o_m_tlast = w_stat.last_chunk;

endmodule

// ===== rtl/nrsf_checker.sv =====
// nrsf_checker: port-level assertions for the rmc sentence framer
// bound to nmea_rmc_sentence_framer; depends on nrsf_pkg for widths

module nrsf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [7:0]  i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [nrsf_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic        o_m_tlast
);

    // stalled chunk holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
        && $stable(o_m_tlast))
        else $error("stalled chunk changed");

    // waiting input transaction holds until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && !o_s_tready |=> i_s_tvalid && $stable(i_s_tdata))
        else $error("waiting input byte changed");

    // no input taken while a chunk is offered
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready during sentence output");

    // every chunk but the last is full
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> o_m_tdata[67:64] == 4'd8)
        else $error("short chunk before last");

    // chunk byte count in range
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[67:64] != 4'd0 && o_m_tdata[67:64] <= 4'd8)
        else $error("bad byte count");

endmodule

bind nmea_rmc_sentence_framer nrsf_checker u_nrsf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

// ===== tb/nmea_rmc_sentence_framer_tb.sv =====
// testbench for nmea_rmc_sentence_framer: raw bytes in, checked 8-byte sentence chunks out
// depends on the rtl top level and nrsf_pkg; self-checking with a behavioral sentence predictor
`timescale 1ns / 1ps

module nmea_rmc_sentence_framer_tb;

    localparam int          STORE_DEPTH = 128;
    localparam int          HUNT_BYTES  = 6;
    localparam int          MAX_CHUNKS  = 16;
    localparam logic [7:0]  ASTERISK    = 8'h2A;
    localparam logic [47:0] RMC_GP      = "$GPRMC";
    localparam logic [47:0] RMC_GN      = "$GNRMC";

    // how the checksum digits of a generated sentence are formed
    typedef enum logic [1:0] {
        CK_GOOD,
        CK_BAD,
        CK_FIRST_NONHEX,
        CK_SECOND_NONHEX
    } t_cksum_mode;

    // one output chunk, laid out as on o_m_tdata
    typedef struct packed {
        logic [3:0]      pad;
        logic [7:0]      slen;
        logic [3:0]      nbytes;
        logic [7:0][7:0] bytes;
    } t_chunk_word;

    typedef struct packed {
        t_chunk_word word;
        logic        last;
    } t_chunk;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = 8'd0;   // [7:0] rx_byte
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [nrsf_pkg::OUT_TDATA_W-1:0] o_m_tdata;
    // [7:0] byte_0 .. [63:56] byte_7, [67:64] bytes_in_chunk,
    // [75:68] sentence_length, [79:76] zero
    logic        o_m_tlast;   // last_chunk

    nmea_rmc_sentence_framer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // predictor state: sentence store, fill index and running xor
    logic [7:0]  sent_mem [STORE_DEPTH];
    int unsigned sent_fill = 0;
    logic [7:0]  sent_xor  = 8'd0;

    logic [7:0]  rx_pending [$];
    t_chunk      chunk_q [$];
    t_chunk      got_chunk;
    t_chunk      want_chunk;
    logic        field_bad;
    logic        in_fire = 1'b0;
    bit          quiet;
    int unsigned cyc = 0;
    int unsigned n_items = 0;
    int unsigned n_sentences = 0;
    int unsigned n_accepted = 0;
    int unsigned n_chunks = 0;
    int unsigned n_errors = 0;

    initial begin
        foreach (sent_mem[k]) sent_mem[k] = 8'd0;
    end

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
        if (v < 4'd10) return 8'("0") + 8'(v);
        return (lower ? 8'("a") : 8'("A")) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] nonhex_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (hex_digit(c) >= 0) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // predictor: absorb one accepted byte, queue the chunks of a verified sentence
    task automatic frame_rx_byte(input logic [7:0] b);
        logic [7:0]  d0;
        logic [7:0]  sum;
        logic [7:0]  cks;
        int          h0;
        int          h1;
        int unsigned len;
        int unsigned nchunks;
        int unsigned n;
        int unsigned idx;
        t_chunk      c;
        // hunting: slide the header window
        if (sent_fill < HUNT_BYTES) begin
            for (int k = 0; k < HUNT_BYTES - 1; k++) sent_mem[k] = sent_mem[k + 1];
            sent_mem[HUNT_BYTES - 1] = b;
            sent_fill++;
            if (sent_fill == HUNT_BYTES) begin
                if ({sent_mem[0], sent_mem[1], sent_mem[2], sent_mem[3], sent_mem[4],
                     sent_mem[5]} != RMC_GP &&
                    {sent_mem[0], sent_mem[1], sent_mem[2], sent_mem[3], sent_mem[4],
                     sent_mem[5]} != RMC_GN) begin
                    sent_fill--;
                end else begin
                    sent_xor = sent_mem[1] ^ sent_mem[2] ^ sent_mem[3] ^ sent_mem[4]
                               ^ sent_mem[5];
                end
            end
            return;
        end
        // store full: drop the byte and hunt again
        if (sent_fill >= STORE_DEPTH) begin
            foreach (sent_mem[k]) sent_mem[k] = 8'd0;
            sent_fill = 0;
            sent_xor  = 8'd0;
            return;
        end
        sent_mem[sent_fill] = b;
        // second digit after '*': compare checksum
        if (sent_mem[sent_fill - 2] == ASTERISK) begin
            d0  = sent_mem[sent_fill - 1];
            sum = sent_xor ^ ASTERISK ^ d0;
            h0  = hex_digit(d0);
            h1  = hex_digit(b);
            if (h0 < 0) cks = 8'd0;
            else if (h1 < 0) cks = 8'(h0);
            else cks = 8'((h0 << 4) | h1);
            if (sum == cks) begin
                len     = sent_fill + 1;
                nchunks = (len + 7) / 8;
                if (nchunks > MAX_CHUNKS) nchunks = MAX_CHUNKS;
                for (int k = 0; k < nchunks; k++) begin
                    n = len - k * 8;
                    if (n > 8) n = 8;
                    for (int j = 0; j < 8; j++) begin
                        idx = k * 8 + j;
                        c.word.bytes[j] = (j < n && idx < STORE_DEPTH) ?
                                          sent_mem[idx] : 8'd0;
                    end
                    c.word.pad    = 4'd0;
                    c.word.nbytes = 4'(n);
                    c.word.slen   = 8'(len);
                    c.last        = (k + 1 == nchunks);
                    chunk_q.push_back(c);
                end
                foreach (sent_mem[k]) sent_mem[k] = 8'd0;
                sent_fill = 0;
                sent_xor  = 8'd0;
                return;
            end
        end
        sent_xor = sent_xor ^ b;
        sent_fill++;
    endtask

    task automatic queue_rx_byte(input logic [7:0] b);
        rx_pending.push_back(b);
        n_items++;
    endtask

    // build one rmc sentence with random body and the chosen checksum style
    task automatic queue_sentence(input bit gn, input int unsigned body_len,
                                  input t_cksum_mode mode);
        logic [47:0] hdr;
        logic [7:0]  acc;
        logic [7:0]  b;
        logic [7:0]  target;
        logic [7:0]  fix;
        logic [7:0]  d0;
        logic [7:0]  d1;
        bit          lower;
        hdr   = gn ? RMC_GN : RMC_GP;
        acc   = 8'd0;
        lower = bit'($urandom_range(0, 1));
        n_sentences++;
        for (int k = 5; k >= 0; k--) begin
            b = hdr[8*k +: 8];
            queue_rx_byte(b);
            if (k != 5) acc = acc ^ b;
        end
        for (int k = 0; k < body_len; k++) begin
            b = 8'($urandom_range(0, 255));
            while (b == ASTERISK) b = 8'($urandom_range(0, 255));
            queue_rx_byte(b);
            acc = acc ^ b;
        end
        case (mode)
            CK_FIRST_NONHEX:  target = 8'd0;
            CK_SECOND_NONHEX: target = 8'($urandom_range(0, 15));
            default:          target = acc;
        endcase
        // pad byte that steers the xor onto the target, never a '*'
        if (acc != target) begin
            fix = acc ^ target;
            if (fix == ASTERISK) begin
                queue_rx_byte(8'h01);
                fix = fix ^ 8'h01;
            end
            queue_rx_byte(fix);
        end
        queue_rx_byte(ASTERISK);
        case (mode)
            CK_GOOD: begin
                d0 = hex_char(target[7:4], lower);
                d1 = hex_char(target[3:0], lower);
            end
            CK_BAD: begin
                d0 = hex_char(target[7:4], lower);
                d1 = hex_char(target[3:0] ^ 4'($urandom_range(1, 15)), lower);
            end
            CK_FIRST_NONHEX: begin
                d0 = nonhex_char();
                d1 = 8'($urandom_range(0, 255));
            end
            default: begin
                d0 = hex_char(target[3:0], lower);
                d1 = nonhex_char();
            end
        endcase
        queue_rx_byte(d0);
        queue_rx_byte(d1);
    endtask

    // byte source and chunk sink, driven on the falling edge
    always @(negedge i_clk) begin
        cyc++;
        quiet = (cyc >= 600 && cyc < 1400);
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_m_tready <= 1'b0;
        end else begin
            if (!i_s_tvalid || in_fire) begin
                if (rx_pending.size() != 0 && (quiet || $urandom_range(0, 99) >= 6)) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= rx_pending.pop_front();
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
            i_m_tready <= quiet || ($urandom_range(0, 99) >= 6);
        end
    end

    // monitor: check chunk transactions, then predict from the accepted byte
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got_chunk.word = t_chunk_word'(o_m_tdata);
                got_chunk.last = o_m_tlast;
                n_chunks++;
                if (chunk_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("chunk %0d with none predicted: data %h last %b",
                                 n_chunks, o_m_tdata, o_m_tlast);
                end else begin
                    want_chunk = chunk_q.pop_front();
                    field_bad = (got_chunk.word.nbytes != want_chunk.word.nbytes)
                             || (got_chunk.word.slen != want_chunk.word.slen)
                             || (got_chunk.word.pad != want_chunk.word.pad)
                             || (got_chunk.last != want_chunk.last);
                    for (int j = 0; j < 8; j++)
                        if (got_chunk.word.bytes[j] != want_chunk.word.bytes[j])
                            field_bad = 1'b1;
                    if (field_bad) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("chunk %0d mismatch: expected %h last %b, got %h last %b",
                                     n_chunks, want_chunk.word, want_chunk.last,
                                     got_chunk.word, got_chunk.last);
                    end
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                frame_rx_byte(i_s_tdata);
                n_accepted++;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        int unsigned pick;
        int unsigned body;
        // directed: byte extremes, shortest sentences with a good checksum and with each non-hex checksum digit
        queue_rx_byte(8'h00);
        queue_rx_byte(8'hFF);
        queue_sentence(1'b0, 0, CK_GOOD);
        queue_sentence(1'b1, 0, CK_SECOND_NONHEX);
        queue_sentence(1'b0, 0, CK_FIRST_NONHEX);
        // random: mostly well-formed sentences, some noise, broken headers, overflow
        while (n_items < 380) begin
            pick = $urandom_range(0, 99);
            body = $urandom_range(0, 99);
            if (body < 80) body = $urandom_range(0, 24);
            else if (body < 95) body = $urandom_range(25, 60);
            else body = $urandom_range(100, 117);
            if (pick < 62) begin
                queue_sentence(bit'($urandom_range(0, 1)), body, CK_GOOD);
            end else if (pick < 70) begin
                queue_sentence(bit'($urandom_range(0, 1)), body, CK_FIRST_NONHEX);
            end else if (pick < 78) begin
                queue_sentence(bit'($urandom_range(0, 1)), body, CK_SECOND_NONHEX);
            end else if (pick < 82) begin
                queue_sentence(bit'($urandom_range(0, 1)), body, CK_BAD);
            end else if (pick < 92) begin
                repeat ($urandom_range(1, 6)) queue_rx_byte(8'($urandom_range(0, 255)));
            end else if (pick < 97) begin
                // truncated header followed by a random byte
                for (int k = 5; k > 5 - int'($urandom_range(1, 5)); k--)
                    queue_rx_byte(8'(($urandom_range(0, 1) ? RMC_GN : RMC_GP) >> (8 * k)));
                queue_rx_byte(8'($urandom_range(0, 255)));
            end else begin
                // header with no '*' until the store overflows
                for (int k = 5; k >= 0; k--) queue_rx_byte(RMC_GP[8*k +: 8]);
                repeat (126) queue_rx_byte(8'($urandom_range(0, 41)));
            end
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (rx_pending.size() != 0 || i_s_tvalid) @(posedge i_clk);
        while (chunk_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("accepted %0d serial bytes from %0d generated sentences plus noise",
                 n_accepted, n_sentences);
        $display("checked %0d sentence chunks, %0d mismatches", n_chunks, n_errors);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #400_000;
        $display("timeout with %0d chunks still predicted", chunk_q.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/nrsf_pkg.sv
rtl/nrsf_ctrl.sv
rtl/nrsf_dp.sv
rtl/nmea_rmc_sentence_framer.sv
rtl/nrsf_checker.sv
tb/nmea_rmc_sentence_framer_tb.sv
